// ===== hdl/bmhq_pkg.sv =====
package bmhq_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned HndW = 16;
  localparam int unsigned CntOutW = 9;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_RESERVED  = 2'd3
  } status_e;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [KeyW-1:0] key;
    logic [HndW-1:0] handle;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_POPRD,
    BK_UPRD,
    BK_UPCMP,
    BK_DNRD,
    BK_DNCMP,
    BK_DONE
  } back_state_e;

endpackage

// ===== hdl/binary_min_heap_queue_top.sv =====
// Channel | Direction | Signals
// input   | in        | valid_i, ready_o, kind_i, key_i, handle_i
// result  | out       | valid_o, ready_i, status_o, popped_*_o, top_*_o, count_o, is_empty_o
//
// The heap engine runs one item at a time. Every sift step reads the heap
// memory through registered read ports, so each level climbed or descended
// takes a read state and a compare state (UPRD/UPCMP, DNRD/DNCMP). A pop
// takes the root and the last entry in POPRD; a refused item goes
// straight to DONE. Each item is registered in the command queue first.
// A stalled result holds the engine; the two-item command queue keeps taking
// input items meanwhile and then drops ready_o.
// Reset clears the count and control; the heap memory needs no clearing.
module binary_min_heap_queue_top #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        kind_i,
  input  logic [31:0] key_i,
  input  logic [15:0] handle_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] popped_key_o,
  output logic [15:0] popped_handle_o,
  output logic [31:0] top_key_o,
  output logic [15:0] top_handle_o,
  output logic [8:0]  count_o,
  output logic        is_empty_o
);

  // Commands pass from the front queue to the heap engine.
  logic           cmd_valid, cmd_ready;
  bmhq_pkg::cmd_t cmd;

  bmhq_front u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .kind_i, .key_i, .handle_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  bmhq_back #(.CAPACITY(CAPACITY)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .valid_o, .ready_i, .status_o, .popped_key_o, .popped_handle_o,
    .top_key_o, .top_handle_o, .count_o, .is_empty_o
  );

endmodule

// ===== hdl/bmhq_front.sv =====
module bmhq_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic            kind_i,
  input  logic [31:0]     key_i,
  input  logic [15:0]     handle_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output bmhq_pkg::cmd_t  cmd_o
);

  // Two-entry command queue between the handshake and the heap engine.
  bmhq_pkg::cmd_t slot_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     fill_q;
  logic           push, pop;

  assign ready_o     = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_q];
  assign push        = valid_i && ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= '{op: bmhq_pkg::op_e'(kind_i), key: key_i, handle: handle_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/bmhq_back.sv =====
module bmhq_back #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  bmhq_pkg::cmd_t       cmd_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output logic [1:0]           status_o,
  output logic [31:0]          popped_key_o,
  output logic [15:0]          popped_handle_o,
  output logic [31:0]          top_key_o,
  output logic [15:0]          top_handle_o,
  output logic [8:0]           count_o,
  output logic                 is_empty_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = AW + 2;
  localparam int unsigned KW = bmhq_pkg::KeyW;
  localparam int unsigned HW = bmhq_pkg::HndW;
  localparam int unsigned EW = KW + HW;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  logic [EW-1:0] mem [CAPACITY];

  bmhq_pkg::back_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] pos_q, pos_d;
  logic [EW-1:0] cur_q, cur_d;        // entry being sifted
  logic [EW-1:0] root_q, root_d;
  logic [EW-1:0] popped_q, popped_d;
  logic [1:0]    status_q, status_d;

  // Read ports: A and B registered.
  logic [AW-1:0] ra_a, ra_b;
  logic [EW-1:0] rd_a_q, rd_b_q;
  logic          we;
  logic [AW-1:0] wa;
  logic [EW-1:0] wd;

  logic [IW-1:0] lidx, ridx;
  logic [AW-1:0] par;
  logic          has_l, has_r, pick_r;
  logic          cur_lt_par, child_lt_cur;
  logic [EW-1:0] child;
  logic [AW-1:0] child_idx;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_a_q <= mem[ra_a];
    rd_b_q <= mem[ra_b];
  end

  assign lidx         = IW'({pos_q, 1'b1});
  assign ridx         = lidx + IW'(1);
  assign par          = AW'((pos_q - AW'(1)) >> 1);
  assign has_l        = (lidx < IW'(cnt_q));
  assign has_r        = (ridx < IW'(cnt_q));
  assign pick_r       = has_r && (rd_b_q[EW-1 -: KW] < rd_a_q[EW-1 -: KW]);
  assign child        = pick_r ? rd_b_q : rd_a_q;
  assign child_idx    = pick_r ? AW'(ridx) : AW'(lidx);
  assign cur_lt_par   = (cur_q[EW-1 -: KW] < rd_a_q[EW-1 -: KW]);
  assign child_lt_cur = (child[EW-1 -: KW] < cur_q[EW-1 -: KW]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      bmhq_pkg::BK_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.op == bmhq_pkg::OP_PUSH) begin
            state_d = (cnt_q >= CapC) ? bmhq_pkg::BK_DONE : bmhq_pkg::BK_UPRD;
          end else begin
            state_d = (cnt_q == '0) ? bmhq_pkg::BK_DONE : bmhq_pkg::BK_POPRD;
          end
        end
      end
      bmhq_pkg::BK_POPRD: state_d = bmhq_pkg::BK_DNRD;
      bmhq_pkg::BK_UPRD: begin
        state_d = (pos_q == '0) ? bmhq_pkg::BK_DONE : bmhq_pkg::BK_UPCMP;
      end
      bmhq_pkg::BK_UPCMP: begin
        state_d = cur_lt_par ? bmhq_pkg::BK_UPRD : bmhq_pkg::BK_DONE;
      end
      bmhq_pkg::BK_DNRD: begin
        state_d = has_l ? bmhq_pkg::BK_DNCMP : bmhq_pkg::BK_DONE;
      end
      bmhq_pkg::BK_DNCMP: begin
        state_d = child_lt_cur ? bmhq_pkg::BK_DNRD : bmhq_pkg::BK_DONE;
      end
      bmhq_pkg::BK_DONE: if (ready_i) state_d = bmhq_pkg::BK_IDLE;
      default: state_d = bmhq_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q; pos_d = pos_q; cur_d = cur_q; root_d = root_q;
    popped_d = popped_q; status_d = status_q;
    we = 1'b0; wa = pos_q; wd = cur_q;
    ra_a = AW'(lidx); ra_b = AW'(ridx);
    cmd_ready_o = 1'b0;
    case (state_q)
      bmhq_pkg::BK_IDLE: begin
        cmd_ready_o = 1'b1;
        ra_a = '0;
        ra_b = AW'(cnt_q - CW'(1));
        if (cmd_valid_i) begin
          status_d = bmhq_pkg::ST_OK;
          popped_d = '0;
          if (cmd_i.op == bmhq_pkg::OP_PUSH) begin
            if (cnt_q >= CapC) begin
              status_d = bmhq_pkg::ST_FULL;
            end else begin
              cur_d = {cmd_i.key, cmd_i.handle};
              pos_d = AW'(cnt_q);
              cnt_d = cnt_q + CW'(1);
            end
          end else begin
            if (cnt_q == '0) begin
              status_d = bmhq_pkg::ST_EMPTY;
            end else begin
              cnt_d = cnt_q - CW'(1);
              pos_d = '0;
            end
          end
        end
      end
      bmhq_pkg::BK_POPRD: begin
        // rd_a_q holds the root, rd_b_q the last entry.
        popped_d = rd_a_q;
        cur_d    = rd_b_q;
      end
      bmhq_pkg::BK_UPRD: begin
        ra_a = par;
        if (pos_q == '0) begin
          we = 1'b1; wa = '0; wd = cur_q;
          root_d = cur_q;
        end
      end
      bmhq_pkg::BK_UPCMP: begin
        // The parent moves down, or the climbing entry settles here.
        we = 1'b1;
        if (cur_lt_par) begin
          wd = rd_a_q;
          pos_d = par;
        end else begin
          wd = cur_q;
        end
      end
      bmhq_pkg::BK_DNRD: begin
        if (!has_l) begin
          we = 1'b1; wd = cur_q;
          if (pos_q == '0) root_d = cur_q;
        end
      end
      bmhq_pkg::BK_DNCMP: begin
        we = 1'b1;
        if (child_lt_cur) begin
          wd = child;
          pos_d = child_idx;
          if (pos_q == '0) root_d = child;
        end else begin
          wd = cur_q;
          if (pos_q == '0) root_d = cur_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bmhq_pkg::BK_IDLE;
      cnt_q    <= '0;
      status_q <= bmhq_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    cur_q    <= cur_d;
    root_q   <= root_d;
    popped_q <= popped_d;
  end

  assign valid_o         = (state_q == bmhq_pkg::BK_DONE);
  assign status_o        = status_q;
  assign popped_key_o    = popped_q[EW-1 -: KW];
  assign popped_handle_o = popped_q[HW-1:0];
  assign top_key_o       = (cnt_q == '0) ? '0 : root_q[EW-1 -: KW];
  assign top_handle_o    = (cnt_q == '0) ? '0 : root_q[HW-1:0];
  assign count_o         = 9'(cnt_q);
  assign is_empty_o      = (cnt_q == '0);

  property p_cnt_bound;
    @(posedge clk_i) disable iff (!rst_ni) cnt_q <= CapC;
  endproperty
  assert property (p_cnt_bound) else $error("count beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == bmhq_pkg::ST_EMPTY) |-> is_empty_o)
    else $error("empty refusal with entries");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == bmhq_pkg::ST_FULL) |-> cnt_q == CapC)
    else $error("full refusal below capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> valid_o && $stable(cnt_q))
    else $error("result dropped");

endmodule

// ===== sim/binary_min_heap_queue_top_test.sv =====
`timescale 1ns / 100ps

module binary_min_heap_queue_top_test;

  localparam int unsigned Depth = 256;
  localparam int unsigned StallLimit = 5000;

  // One result of the queue, as the result channel carries it.
  typedef struct {
    bmhq_pkg::status_e status;
    logic [31:0] popped_key;
    logic [15:0] popped_handle;
    logic [31:0] top_key;
    logic [15:0] top_handle;
    logic [8:0]  count;
    logic        is_empty;
  } heap_result_t;

  // One row of the directed table. Where has_want is set, the expected result
  // is the typed one; otherwise it comes from the heap predictor.
  typedef struct {
    bmhq_pkg::op_e op;
    logic [31:0]  key;
    logic [15:0]  handle;
    bit           has_want;
    heap_result_t want;
  } heap_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        ready_o;
  logic        kind_i;
  logic [31:0] key_i;
  logic [15:0] handle_i;
  logic        valid_o;
  logic        ready_i;
  logic [1:0]  status_o;
  logic [31:0] popped_key_o;
  logic [15:0] popped_handle_o;
  logic [31:0] top_key_o;
  logic [15:0] top_handle_o;
  logic [8:0]  count_o;
  logic        is_empty_o;

  binary_min_heap_queue_top #(.CAPACITY(Depth)) dut (
    .clk_i,
    .rst_ni,
    .valid_i,
    .ready_o,
    .kind_i,
    .key_i,
    .handle_i,
    .valid_o,
    .ready_i,
    .status_o,
    .popped_key_o,
    .popped_handle_o,
    .top_key_o,
    .top_handle_o,
    .count_o,
    .is_empty_o
  );

  // The predictor keeps its own copy of the heap: keys, handles and a count.
  logic [31:0]  shadow_key [Depth];
  logic [15:0]  shadow_hnd [Depth];
  int unsigned  shadow_count;

  heap_result_t pending_results[$];
  int unsigned  mismatches;
  int unsigned  n_push, n_pop, n_full, n_empty, n_results;
  bit           idle_on;
  int unsigned  stall_cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [31:0] k;
    logic [15:0] h;
    k = shadow_key[a];
    h = shadow_hnd[a];
    shadow_key[a] = shadow_key[b];
    shadow_hnd[a] = shadow_hnd[b];
    shadow_key[b] = k;
    shadow_hnd[b] = h;
  endfunction

  // Applies one item to the shadow heap and returns the result it should cause.
  function automatic heap_result_t heap_apply(bmhq_pkg::op_e op, logic [31:0] key,
                                              logic [15:0] hnd);
    heap_result_t r;
    int unsigned  pos, up, l, rt, pick;
    r.status = bmhq_pkg::ST_OK;
    r.popped_key = '0;
    r.popped_handle = '0;
    if (op == bmhq_pkg::OP_PUSH) begin
      if (shadow_count >= Depth) begin
        r.status = bmhq_pkg::ST_FULL;
        n_full++;
      end else begin
        n_push++;
        pos = shadow_count;
        shadow_key[pos] = key;
        shadow_hnd[pos] = hnd;
        shadow_count++;
        // Climb while strictly smaller than the parent.
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (shadow_key[pos] < shadow_key[up]) begin
            swap_slots(pos, up);
            pos = up;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = bmhq_pkg::ST_EMPTY;
        n_empty++;
      end else begin
        n_pop++;
        r.popped_key = shadow_key[0];
        r.popped_handle = shadow_hnd[0];
        shadow_count--;
        shadow_key[0] = shadow_key[shadow_count];
        shadow_hnd[0] = shadow_hnd[shadow_count];
        pos = 0;
        // Descend toward the smaller child; a tie keeps the left one.
        forever begin
          l = 2 * pos + 1;
          rt = l + 1;
          if (l >= shadow_count) break;
          pick = l;
          if (rt < shadow_count && shadow_key[rt] < shadow_key[l]) pick = rt;
          if (shadow_key[pick] < shadow_key[pos]) begin
            swap_slots(pos, pick);
            pos = pick;
          end else begin
            break;
          end
        end
      end
    end
    r.top_key = shadow_count != 0 ? shadow_key[0] : '0;
    r.top_handle = shadow_count != 0 ? shadow_hnd[0] : '0;
    r.count = shadow_count[8:0];
    r.is_empty = shadow_count == 0;
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH result %0d %s: got 0x%0h, expected 0x%0h",
             n_results, field, got, want);
    mismatches++;
  endtask

  // Offers one item and holds it until accepted. Called and returns at a
  // falling edge; valid stays high into the next item unless a random idle gap is inserted.
  task automatic send_item(bmhq_pkg::op_e op, logic [31:0] key, logic [15:0] hnd,
                           bit has_want, heap_result_t want);
    heap_result_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    valid_i = 1'b1;
    kind_i = op;
    key_i = key;
    handle_i = hnd;
    do @(posedge clk_i); while (!ready_o);
    predicted = heap_apply(op, key, hnd);
    pending_results.push_back(has_want ? want : predicted);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0:       return 32'hFFFF_FFFF;
      1:       return 32'h0;
      2, 3, 4: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic heap_result_t mk_result(bmhq_pkg::status_e st, logic [31:0] pk,
                                             logic [15:0] ph, logic [31:0] tk,
                                             logic [15:0] th, logic [8:0] cnt);
    heap_result_t r;
    r.status = st;
    r.popped_key = pk;
    r.popped_handle = ph;
    r.top_key = tk;
    r.top_handle = th;
    r.count = cnt;
    r.is_empty = cnt == 0;
    return r;
  endfunction

  // The receiver stalls in random bursts until the last part of the run.
  initial begin
    int unsigned burst;
    ready_i = 1'b0;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (burst != 0) begin
        burst--;
        ready_i = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 5);
        ready_i = 1'b0;
      end else begin
        ready_i = 1'b1;
      end
    end
  end

  // Results are compared with the oldest expectation at the rising edge.
  always @(posedge clk_i) begin
    heap_result_t want;
    if (rst_ni && valid_o && ready_i) begin
      n_results++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        want = pending_results.pop_front();
        if (status_o != want.status)
          report_mismatch("status", 32'(status_o), 32'(want.status));
        if (popped_key_o != want.popped_key)
          report_mismatch("popped_key", popped_key_o, want.popped_key);
        if (popped_handle_o != want.popped_handle)
          report_mismatch("popped_handle", 32'(popped_handle_o), 32'(want.popped_handle));
        if (top_key_o != want.top_key) report_mismatch("top_key", top_key_o, want.top_key);
        if (top_handle_o != want.top_handle)
          report_mismatch("top_handle", 32'(top_handle_o), 32'(want.top_handle));
        if (count_o != want.count)
          report_mismatch("count", 32'(count_o), 32'(want.count));
        if (is_empty_o != want.is_empty)
          report_mismatch("is_empty", 32'(is_empty_o), 32'(want.is_empty));
      end
    end
  end

  // The watchdog ends a run in which nothing moves for too long.
  always @(posedge clk_i) begin
    if ((valid_i && ready_o) || (valid_o && ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Stalled with %0d results outstanding", pending_results.size());
      $display("binary_min_heap_queue_top verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    heap_row_t     rows[$];
    heap_row_t     row;
    heap_result_t  none;
    bmhq_pkg::op_e op;
    int unsigned   target;

    rst_ni = 1'b0;
    valid_i = 1'b0;
    kind_i = bmhq_pkg::OP_PUSH;
    key_i = '0;
    handle_i = '0;
    idle_on = 1'b1;
    stall_cycles = 0;
    mismatches = 0;
    n_push = 0;
    n_pop = 0;
    n_full = 0;
    n_empty = 0;
    n_results = 0;
    shadow_count = 0;
    none = mk_result(bmhq_pkg::ST_OK, '0, '0, '0, '0, '0);

    // Directed table: empty pops, field extremes, ties and the last-entry pop.
    rows = '{
      '{bmhq_pkg::OP_POP,  32'h1234_5678, 16'hABCD, 1,
        mk_result(bmhq_pkg::ST_EMPTY, '0, '0, '0, '0, '0)},
      '{bmhq_pkg::OP_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 1,
        mk_result(bmhq_pkg::ST_OK, '0, '0, 32'hFFFF_FFFF, 16'hFFFF, 9'd1)},
      '{bmhq_pkg::OP_PUSH, 32'h0, 16'h0, 1,
        mk_result(bmhq_pkg::ST_OK, '0, '0, '0, '0, 9'd2)},
      '{bmhq_pkg::OP_POP,  32'h0, 16'h0, 1,
        mk_result(bmhq_pkg::ST_OK, '0, '0, 32'hFFFF_FFFF, 16'hFFFF, 9'd1)},
      '{bmhq_pkg::OP_POP,  32'hFFFF_FFFF, 16'hFFFF, 1,
        mk_result(bmhq_pkg::ST_OK, 32'hFFFF_FFFF, 16'hFFFF, '0, '0, '0)},
      '{bmhq_pkg::OP_POP,  32'h0, 16'h0, 1,
        mk_result(bmhq_pkg::ST_EMPTY, '0, '0, '0, '0, '0)},
      '{bmhq_pkg::OP_PUSH, 32'd5, 16'h0001, 0, none},
      '{bmhq_pkg::OP_PUSH, 32'd5, 16'h0002, 0, none},
      '{bmhq_pkg::OP_PUSH, 32'd5, 16'h0003, 0, none},
      '{bmhq_pkg::OP_PUSH, 32'd3, 16'h5555, 0, none},
      '{bmhq_pkg::OP_PUSH, 32'd9, 16'hAAAA, 0, none},
      '{bmhq_pkg::OP_PUSH, 32'h8000_0000, 16'h8000, 0, none},
      '{bmhq_pkg::OP_PUSH, 32'h7FFF_FFFF, 16'h7FFF, 0, none},
      '{bmhq_pkg::OP_PUSH, 32'd1, 16'h00FF, 0, none},
      '{bmhq_pkg::OP_POP,  32'h0, 16'h0, 0, none},
      '{bmhq_pkg::OP_POP,  32'h0, 16'h0, 0, none},
      '{bmhq_pkg::OP_POP,  32'h0, 16'h0, 0, none},
      '{bmhq_pkg::OP_POP,  32'h0, 16'h0, 0, none},
      '{bmhq_pkg::OP_POP,  32'h0, 16'h0, 0, none},
      '{bmhq_pkg::OP_POP,  32'h0, 16'h0, 0, none},
      '{bmhq_pkg::OP_POP,  32'h0, 16'h0, 0, none},
      '{bmhq_pkg::OP_POP,  32'h0, 16'h0, 0, none},
      '{bmhq_pkg::OP_POP,  32'h0, 16'h0, 0, none}
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.op, row.key, row.handle, row.has_want, row.want);
    end

    // Random mix whose push rate follows a wandering fill target, so the
    // queue passes through shallow and deep trees alike.
    target = 20;
    repeat (80) begin
      if ($urandom_range(0, 29) == 0) target = $urandom_range(0, 200);
      if ($urandom_range(0, 9) == 0) op = bmhq_pkg::op_e'($urandom_range(0, 1));
      else op = shadow_count < target ? bmhq_pkg::OP_PUSH : bmhq_pkg::OP_POP;
      send_item(op, pick_key(), 16'($urandom), 0, none);
    end

    // Hold the input back until every outstanding result has drained.
    valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);

    // Fill to capacity and beyond, then drain past empty.
    while (shadow_count < Depth)
      send_item(bmhq_pkg::OP_PUSH, pick_key(), 16'($urandom), 0, none);
    repeat (3) send_item(bmhq_pkg::OP_PUSH, pick_key(), 16'($urandom), 0, none);
    repeat (40)
      send_item(bmhq_pkg::op_e'($urandom_range(0, 1)), pick_key(), 16'($urandom), 0, none);
    while (shadow_count > 0) send_item(bmhq_pkg::OP_POP, '0, '0, 0, none);
    repeat (2) send_item(bmhq_pkg::OP_POP, 32'($urandom), 16'($urandom), 0, none);

    // Last part at full rate on both sides.
    idle_on = 1'b0;
    repeat (40) begin
      op = (shadow_count < 10 || $urandom_range(0, 2) != 0) ? bmhq_pkg::OP_PUSH
                                                             : bmhq_pkg::OP_POP;
      send_item(op, pick_key(), 16'($urandom), 0, none);
    end
    valid_i = 1'b0;

    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Covered %0d pushes, %0d pops, %0d refused when full, %0d refused when empty.",
             n_push, n_pop, n_full, n_empty);
    $display("Checked %0d results, %0d mismatching fields.", n_results, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("binary_min_heap_queue_top verification clean");
    end else begin
      $display("binary_min_heap_queue_top verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/bmhq_pkg.sv
hdl/bmhq_front.sv
hdl/bmhq_back.sv
hdl/binary_min_heap_queue_top.sv
sim/binary_min_heap_queue_top_test.sv
